@@ hw/rtl/htqp_pkg.sv @@
// shared constants, codes and types for the quadratic-probe hash table
package htqp_pkg;

  // table geometry
  localparam int CAPACITY   = 256;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int CNT_W      = SLOT_BITS + 1;
  localparam int VALUE_BITS = 64;

  // field widths
  localparam int HASH_W   = 32;
  localparam int VALUE_W  = 64;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 8;
  localparam int LIVE_W   = 9;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 8'd125;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_EXISTS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FETCH  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STORE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LENGTH = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // one slot of the table memory
  typedef struct packed {
    logic [HASH_W-1:0]     key;
    logic                  is_null;
    logic [VALUE_BITS-1:0] value;
  } slot_entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic act;
  } htqp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic probe_stop;
  } htqp_stat_t;

endpackage

@@ hw/rtl/htqp_if.sv @@
// request and result channel interfaces
interface htqp_req_if
  import htqp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [HASH_W-1:0] key_hash;
  logic [VALUE_W-1:0] value;
  logic              value_null;

  modport source (output valid, mode, key_hash, value, value_null, input ready);
  modport sink   (input valid, mode, key_hash, value, value_null, output ready);
endinterface

interface htqp_rsp_if
  import htqp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                found;
  logic [VALUE_W-1:0]  result_value;
  logic                result_null;
  logic [STATUS_W-1:0] status;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, found, result_value, result_null, status, live_count,
                  input ready);
  modport sink   (input valid, found, result_value, result_null, status, live_count,
                  output ready);
endinterface

@@ hw/rtl/htqp_ctrl.sv @@
// sequencing state machine: accept, probe, apply, hand off result
module htqp_ctrl
  import htqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output htqp_cmd_t  cmd,
  input  htqp_stat_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_ACT   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       res_free;

  // result register is free when empty or being taken now
  assign res_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.probe_stop) begin
          state_nxt = S_ACT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_ACT: begin
        if (res_free) begin
          cmd.act   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.act) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/htqp_datapath.sv @@
// slot memory, used bits, probe index, counters and result register
module htqp_datapath
  import htqp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [HASH_W-1:0]   in_key_hash,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                in_value_null,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  input  htqp_cmd_t           cmd,
  output htqp_stat_t          stat,
  output logic                out_found,
  output logic [VALUE_W-1:0]  out_result_value,
  output logic                out_result_null,
  output logic [STATUS_W-1:0] out_status,
  output logic [LIVE_W-1:0]   out_live_count
);

  slot_entry_t mem [CAPACITY];
  slot_entry_t rd_data_r;
  slot_entry_t wr_entry;
  logic        wr_en;

  logic [CAPACITY-1:0]   used_r;
  logic [LIMIT_W-1:0]    load_limit_r;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [CNT_W-1:0]      nonnull_r, nonnull_nxt;

  logic [MODE_W-1:0]     req_mode_r;
  logic [HASH_W-1:0]     req_hash_r;
  logic [VALUE_BITS-1:0] req_value_r;
  logic                  req_null_r;

  logic [SLOT_BITS-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]       j_r;
  logic [2*SLOT_BITS-1:0] j_sq;

  logic used_s, key_eq, hit, place_ok, set_used, clr_used;

  logic                found_c;
  logic [VALUE_W-1:0]  rval_c;
  logic                rnull_c;
  logic [STATUS_W-1:0] status_c;

  logic                out_found_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_null_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LIVE_W-1:0]   out_live_r;

  // probe step: i = (i + j*j) mod capacity
  assign j_sq = j_r[SLOT_BITS-1:0] * j_r[SLOT_BITS-1:0];

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = in_key_hash[SLOT_BITS-1:0];
    end else if (cmd.step) begin
      idx_nxt = idx_r + j_sq[SLOT_BITS-1:0];
    end
  end

  // slot test on the current probe index
  assign used_s          = used_r[idx_r];
  assign key_eq          = (rd_data_r.key == req_hash_r);
  assign hit             = used_s && key_eq;
  assign stat.probe_stop = !used_s || key_eq || (j_r == CNT_W'(CAPACITY));
  assign place_ok        = !used_s && (occ_r < CNT_W'(load_limit_r));

  // operation outcome
  always_comb begin
    found_c     = hit;
    rval_c      = '0;
    rnull_c     = 1'b0;
    status_c    = ST_OK;
    wr_en       = 1'b0;
    wr_entry    = '{key: req_hash_r, is_null: 1'b1, value: '0};
    set_used    = 1'b0;
    clr_used    = 1'b0;
    occ_nxt     = occ_r;
    nonnull_nxt = nonnull_r;
    unique case (req_mode_r)
      MODE_EXISTS: begin
      end
      MODE_FETCH: begin
        if (hit) begin
          rval_c  = VALUE_W'(rd_data_r.value);
          rnull_c = rd_data_r.is_null;
        end else begin
          rnull_c = 1'b1;
          if (place_ok) begin
            wr_en    = 1'b1;
            set_used = 1'b1;
            occ_nxt  = occ_r + 1'b1;
          end else begin
            status_c = ST_FULL;
          end
        end
      end
      MODE_STORE: begin
        wr_entry = '{key: req_hash_r, is_null: req_null_r, value: req_value_r};
        if (hit) begin
          wr_en   = 1'b1;
          rval_c  = VALUE_W'(req_value_r);
          rnull_c = req_null_r;
          if (rd_data_r.is_null && !req_null_r) begin
            nonnull_nxt = nonnull_r + 1'b1;
          end else if (!rd_data_r.is_null && req_null_r) begin
            nonnull_nxt = nonnull_r - 1'b1;
          end
        end else if (place_ok) begin
          wr_en    = 1'b1;
          set_used = 1'b1;
          occ_nxt  = occ_r + 1'b1;
          rval_c   = VALUE_W'(req_value_r);
          rnull_c  = req_null_r;
          if (!req_null_r) begin
            nonnull_nxt = nonnull_r + 1'b1;
          end
        end else begin
          rnull_c  = 1'b1;
          status_c = ST_FULL;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          rval_c   = VALUE_W'(rd_data_r.value);
          rnull_c  = rd_data_r.is_null;
          clr_used = 1'b1;
          occ_nxt  = occ_r - 1'b1;
          if (!rd_data_r.is_null) begin
            nonnull_nxt = nonnull_r - 1'b1;
          end
        end else begin
          rnull_c  = 1'b1;
          status_c = ST_NOT_FOUND;
        end
      end
      default: begin
        // length and unused codes change nothing
        found_c = 1'b0;
      end
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.act && wr_en) begin
      mem[idx_r] <= wr_entry;
    end
    rd_data_r <= mem[idx_nxt];
  end

  // control state: used bits, counters, load limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      occ_r        <= '0;
      nonnull_r    <= '0;
      load_limit_r <= LOAD_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        load_limit_r <= cfg_wdata;
      end
      if (cmd.act) begin
        occ_r     <= occ_nxt;
        nonnull_r <= nonnull_nxt;
        if (set_used) begin
          used_r[idx_r] <= 1'b1;
        end else if (clr_used) begin
          used_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  // request capture and probe position
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.start) begin
      req_mode_r  <= in_mode;
      req_hash_r  <= in_key_hash;
      req_value_r <= in_value[VALUE_BITS-1:0];
      req_null_r  <= in_value_null;
      j_r         <= CNT_W'(1);
    end else if (cmd.step) begin
      j_r <= j_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      out_found_r  <= found_c;
      out_value_r  <= rval_c;
      out_null_r   <= rnull_c;
      out_status_r <= status_c;
      out_live_r   <= LIVE_W'(nonnull_nxt);
    end
  end

  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;
  assign out_result_null  = out_null_r;
  assign out_status       = out_status_r;
  assign out_live_count   = out_live_r;

endmodule

@@ hw/rtl/hash_table_quadratic_probe.sv @@
// top level of the quadratic-probe hash table
//
// requests arrive on in_ch (mode, key_hash, value, value_null) and one
// result per request leaves on out_ch (found, result_value, result_null,
// status, live_count). cfg_we/cfg_wdata write the load limit, which the user
// must do only while idle; the block itself does not enforce this.
// a request is taken when in_ch.valid and in_ch.ready are high; the block
// then walks the quadratic probe chain, one slot memory read per cycle,
// and applies the operation once the result register is free.
// a request takes P probes (1 to 256, a few on average at under half
// load), read one at a time through the single slot memory read port;
// the next request is taken only after the last one is applied.
// the result sits in an output register, so a new request is accepted
// while the receiver stalls; the block holds in its apply step only when
// a second result is ready and the first has not been taken.
// reset clears all used bits and both counters at once, no clearing pass,
// and restores the load limit to 125.
module hash_table_quadratic_probe
  import htqp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  htqp_req_if.sink           in_ch,
  htqp_rsp_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  htqp_cmd_t  cmd;
  htqp_stat_t stat;

  // sequencing
  htqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // table storage and arithmetic
  htqp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_ch.mode),
    .in_key_hash      (in_ch.key_hash),
    .in_value         (in_ch.value),
    .in_value_null    (in_ch.value_null),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_found        (out_ch.found),
    .out_result_value (out_ch.result_value),
    .out_result_null  (out_ch.result_null),
    .out_status       (out_ch.status),
    .out_live_count   (out_ch.live_count)
  );

`ifndef SYNTHESIS
  // a taken request drops ready until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready stayed high after a request was taken");

  // applying a request always presents a result
  a_act_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.act |=> out_ch.valid)
    else $error("apply step left no result");

  // no new request is started in the same cycle as a probe step or apply
  a_start_not_act: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && (cmd.act || cmd.step)))
    else $error("start overlapped probe or apply");

  // live count never exceeds the table size
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.live_count <= LIVE_W'(CAPACITY)))
    else $error("live count beyond capacity");
`endif

endmodule
